>>> rtl/core/hshp_pkg.sv
package hshp_pkg;

  localparam int TempW  = 16;
  localparam int HumW   = 16;
  localparam int TimeW  = 40;
  localparam int DurW   = 24;
  localparam int PulseW = 16;
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  localparam logic [TempW-1:0]  TempLimitRst   = TempW'(41194);
  localparam logic [HumW-1:0]   RhCondenseRst  = HumW'(62259);
  localparam logic [HumW-1:0]   RhCreepRst     = HumW'(52428);
  localparam logic [DurW-1:0]   CreepIntvRst   = DurW'(30000);
  localparam logic [DurW-1:0]   DutyWindowRst  = DurW'(600000);
  localparam logic [DurW-1:0]   DutyBudgetRst  = DurW'(54000);
  localparam logic [PulseW-1:0] LongPulseRst   = PulseW'(1000);
  localparam logic [PulseW-1:0] ShortPulseRst  = PulseW'(100);

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_LONG  = 2'd2
  } heater_act_e;

  typedef enum logic [2:0] {
    REG_TEMP_LIMIT  = 3'd0,
    REG_RH_CONDENSE = 3'd1,
    REG_RH_CREEP    = 3'd2,
    REG_CREEP_INTV  = 3'd3,
    REG_DUTY_WINDOW = 3'd4,
    REG_DUTY_BUDGET = 3'd5,
    REG_LONG_PULSE  = 3'd6,
    REG_SHORT_PULSE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TempW-1:0]  temp_limit_code;
    logic [HumW-1:0]   rh_condense_code;
    logic [HumW-1:0]   rh_creep_code;
    logic [DurW-1:0]   creep_interval_ms;
    logic [DurW-1:0]   duty_window_ms;
    logic [DurW-1:0]   duty_budget_ms;
    logic [PulseW-1:0] long_pulse_ms;
    logic [PulseW-1:0] short_pulse_ms;
  } cfg_t;

  typedef struct packed {
    logic [TempW-1:0] temp_code;
    logic [HumW-1:0]  humidity_code;
    logic [TimeW-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    heater_act_e action;
    logic        refused;
  } result_t;

endpackage

>>> rtl/core/hshp_if.sv
interface hshp_in_if import hshp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TempW-1:0] temp_code;
  logic [HumW-1:0]  humidity_code;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, temp_code, humidity_code, now_ms, input ready);
  modport sink (input valid, temp_code, humidity_code, now_ms, output ready);
endinterface

interface hshp_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] heater_action;
  logic       budget_refused;

  modport source (output valid, heater_action, budget_refused, input ready);
  modport sink (input valid, heater_action, budget_refused, output ready);
endinterface

>>> rtl/core/humidity_sensor_heater_policy_core.sv
// Channel  Role    Payload
// smp_i    sink    temp_code[15:0], humidity_code[15:0], now_ms[39:0]
// res_o    source  heater_action[1:0], budget_refused
// apb      slave   8 registers at byte address 4*i, 32-bit data
//
// One sample per cycle while res_o.ready holds; the result passes through the input and result registers.
// Input register, then combinational decision and duty state update into the result register.
// Duty state advances only when a sample that requests a pulse moves into the result register.
// A stalled result holds; one sample still waits in the input register.
// Reset: registers take their default values, duty state and valid flags clear.
module humidity_sensor_heater_policy_core import hshp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hshp_in_if.sink           smp_i,
  hshp_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  sample_t smp_q;
  logic    smp_vld_q, smp_vld_d;
  logic    adv;
  logic    in_ready;

  assign in_ready = !smp_vld_q || adv;
  assign pready   = 1'b1;

  always_comb begin
    smp_vld_d = smp_vld_q;
    if (in_ready) begin
      smp_vld_d = smp_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else begin
      smp_vld_q <= smp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && smp_i.valid) begin
      smp_q.temp_code     <= smp_i.temp_code;
      smp_q.humidity_code <= smp_i.humidity_code;
      smp_q.now_ms        <= smp_i.now_ms;
    end
  end

  assign smp_i.ready = in_ready;

  hshp_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  hshp_policy u_policy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .smp_vld_i (smp_vld_q),
    .smp_i     (smp_q),
    .adv_o     (adv),
    .res_o     (res_o)
  );

endmodule

>>> rtl/core/hshp_apb_regs.sv
module hshp_apb_regs import hshp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [PdataW-1:0] pwdata_i,
  output logic [PdataW-1:0] prdata_o,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e wsel;
  logic     wr_en;

  assign wsel  = cfg_reg_e'(paddr_i[PaddrW-1:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (wsel)
        REG_TEMP_LIMIT:  cfg_d.temp_limit_code   = pwdata_i[TempW-1:0];
        REG_RH_CONDENSE: cfg_d.rh_condense_code  = pwdata_i[HumW-1:0];
        REG_RH_CREEP:    cfg_d.rh_creep_code     = pwdata_i[HumW-1:0];
        REG_CREEP_INTV:  cfg_d.creep_interval_ms = pwdata_i[DurW-1:0];
        REG_DUTY_WINDOW: cfg_d.duty_window_ms    = pwdata_i[DurW-1:0];
        REG_DUTY_BUDGET: cfg_d.duty_budget_ms    = pwdata_i[DurW-1:0];
        REG_LONG_PULSE:  cfg_d.long_pulse_ms     = pwdata_i[PulseW-1:0];
        REG_SHORT_PULSE: cfg_d.short_pulse_ms    = pwdata_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit_code   <= TempLimitRst;
      cfg_q.rh_condense_code  <= RhCondenseRst;
      cfg_q.rh_creep_code     <= RhCreepRst;
      cfg_q.creep_interval_ms <= CreepIntvRst;
      cfg_q.duty_window_ms    <= DutyWindowRst;
      cfg_q.duty_budget_ms    <= DutyBudgetRst;
      cfg_q.long_pulse_ms     <= LongPulseRst;
      cfg_q.short_pulse_ms    <= ShortPulseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (wsel)
      REG_TEMP_LIMIT:  prdata_o = PdataW'(cfg_q.temp_limit_code);
      REG_RH_CONDENSE: prdata_o = PdataW'(cfg_q.rh_condense_code);
      REG_RH_CREEP:    prdata_o = PdataW'(cfg_q.rh_creep_code);
      REG_CREEP_INTV:  prdata_o = PdataW'(cfg_q.creep_interval_ms);
      REG_DUTY_WINDOW: prdata_o = PdataW'(cfg_q.duty_window_ms);
      REG_DUTY_BUDGET: prdata_o = PdataW'(cfg_q.duty_budget_ms);
      REG_LONG_PULSE:  prdata_o = PdataW'(cfg_q.long_pulse_ms);
      REG_SHORT_PULSE: prdata_o = PdataW'(cfg_q.short_pulse_ms);
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/hshp_policy.sv
module hshp_policy import hshp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      smp_vld_i,
  input  sample_t   smp_i,
  output logic      adv_o,
  hshp_out_if.source res_o
);

  logic [TimeW-1:0]  window_start_q, window_start_d;
  logic [DurW-1:0]   used_q, used_d;
  logic [TimeW-1:0]  last_heat_q, last_heat_d;
  logic              res_vld_q, res_vld_d;
  result_t           res_q, res_d;

  logic              temp_ok, rh_long, rh_creep, creep_due, want_long, want;
  logic [TimeW-1:0]  since_heat, since_win;
  logic              expired, fits;
  logic [PulseW-1:0] pulse;
  logic [DurW:0]     sum_base;
  logic              adv;

  assign adv = smp_vld_i && (!res_vld_q || res_o.ready);

  always_comb begin
    temp_ok    = smp_i.temp_code < cfg_i.temp_limit_code;
    rh_long    = smp_i.humidity_code >= cfg_i.rh_condense_code;
    rh_creep   = smp_i.humidity_code >= cfg_i.rh_creep_code;
    since_heat = smp_i.now_ms - last_heat_q;
    since_win  = smp_i.now_ms - window_start_q;
    creep_due  = (|since_heat[TimeW-1:DurW]) ||
                 (since_heat[DurW-1:0] >= cfg_i.creep_interval_ms);
    expired    = (|since_win[TimeW-1:DurW]) ||
                 (since_win[DurW-1:0] >= cfg_i.duty_window_ms);
    want_long  = temp_ok && rh_long;
    want       = want_long || (temp_ok && rh_creep && creep_due);
    pulse      = want_long ? cfg_i.long_pulse_ms : cfg_i.short_pulse_ms;
    sum_base   = expired ? (DurW+1)'(pulse)
                         : ({1'b0, used_q} + (DurW+1)'(pulse));
    fits       = sum_base <= {1'b0, cfg_i.duty_budget_ms};

    window_start_d = window_start_q;
    used_d         = used_q;
    last_heat_d    = last_heat_q;
    if (adv && want) begin
      last_heat_d = smp_i.now_ms;
      if (expired) begin
        window_start_d = smp_i.now_ms;
        used_d         = '0;
      end
      if (fits) begin
        used_d = sum_base[DurW-1:0];
      end
    end

    res_d.refused = want && !fits;
    if (want && fits) begin
      res_d.action = want_long ? ACT_LONG : ACT_SHORT;
    end else begin
      res_d.action = ACT_NONE;
    end

    res_vld_d = res_vld_q;
    if (adv) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_start_q <= '0;
      used_q         <= '0;
      last_heat_q    <= '0;
      res_vld_q      <= 1'b0;
    end else begin
      window_start_q <= window_start_d;
      used_q         <= used_d;
      last_heat_q    <= last_heat_d;
      res_vld_q      <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign adv_o                = adv;
  assign res_o.valid          = res_vld_q;
  assign res_o.heater_action  = res_q.action;
  assign res_o.budget_refused = res_q.refused;

`ifndef SYNTHESIS
  a_refused_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.refused |-> res_q.action == ACT_NONE)
    else $error("refused pulse reported as fired");

  a_heat_time_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && want |=> last_heat_q == $past(smp_i.now_ms))
    else $error("last heat time not restarted by a pulse request");

  a_idle_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && want) |=> $stable(window_start_q) && $stable(used_q) && $stable(last_heat_q))
    else $error("duty state moved without a pulse request");

  a_charge_in_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && want && fits |=> used_q <= $past(cfg_i.duty_budget_ms))
    else $error("charged on-time exceeds budget");
`endif

endmodule
